@@ hw/rtl/fmc_pkg.sv @@
package fmc_pkg;

  localparam int BASE_W   = 26;
  localparam int TARGET_W = 27;
  localparam int QUO_W    = 26;            // quotient bits produced by the divider
  localparam int DIV_W    = 23;            // 100 * afr_setpoint fits in 23 bits
  localparam int PROD_W   = 40;            // density * volume * ve
  localparam int HI_W     = PROD_W - QUO_W;

  localparam logic [BASE_W-1:0]   BASE_MAX   = {BASE_W{1'b1}};
  localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};

  localparam int AFR_SCALE = 100;
  localparam int PCT_SCALE = 1600;

  // floor(x / 1600) = floor(floor(x / 64) / 25); divide by 25 via reciprocal
  localparam int PCT_SHIFT = 6;
  localparam logic [31:0] RECIP_25 = 32'h51EB851F;
  localparam int RECIP_SHIFT = 35;
  localparam logic [35:0] TGT_LIMIT = 36'd3355443200;  // 25 * 2^27

  localparam logic [11:0]        CYL_VOL_RST = 12'd0;
  localparam logic signed [15:0] MAX_REL_RST = 16'sd1600;
  localparam logic signed [15:0] MIN_REL_RST = -16'sd800;
  localparam logic [15:0]        MAX_ABS_RST = 16'd10000;

  typedef enum logic [1:0] {
    REG_CYL_VOL = 2'd0,
    REG_MAX_REL = 2'd1,
    REG_MIN_REL = 2'd2,
    REG_MAX_ABS = 2'd3
  } fmc_reg_t;

  typedef struct packed {
    logic [15:0]        charge_density;
    logic [11:0]        ve_percent;
    logic [15:0]        afr_setpoint;
    logic               ase_on;
    logic signed [15:0] ase_percent;
    logic               wue_on;
    logic signed [15:0] wue_percent;
    logic               baro_on;
    logic signed [15:0] baro_percent;
    logic               accel_on;
    logic signed [23:0] accel_mass;
  } fmc_in_t;

  typedef struct packed {
    logic [BASE_W-1:0]   base_mass;
    logic [TARGET_W-1:0] target_mass;
    logic                divide_error;
    logic                rel_clipped;
    logic                abs_clipped;
    logic                saturated;
  } fmc_out_t;

  typedef struct packed {
    logic [11:0]        cylinder_volume;
    logic signed [15:0] max_rel_comp;
    logic signed [15:0] min_rel_comp;
    logic [15:0]        max_abs_comp;
  } fmc_cfg_t;

  // corrections resolved up front, carried alongside the division
  typedef struct packed {
    logic               derr;
    logic signed [15:0] rel;
    logic               relc;
    logic signed [23:0] accel;
    logic               absc;
  } fmc_side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] qp;    // dividend bits shift out of the top, quotient bits in
    logic [DIV_W-1:0] d;
    logic             ovf;
    fmc_side_t        side;
  } fmc_dq_t;

endpackage

@@ hw/rtl/fmc_air.sv @@
module fmc_air (
  input  logic              clk,
  input  logic              rst_n,
  input  fmc_pkg::fmc_cfg_t cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  fmc_pkg::fmc_in_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fmc_pkg::fmc_dq_t  dn_data
);

  logic [2:0] v_r;
  logic [2:0] en;

  // stage 0: density * volume, divisor, corrections
  logic [27:0]                  p1_r, p1_nxt;
  logic [11:0]                  ve_r;
  logic [fmc_pkg::DIV_W-1:0]    d0_r, d0_nxt;
  fmc_pkg::fmc_side_t           side0_r, side0_nxt;

  // stage 1: full product
  logic [fmc_pkg::PROD_W-1:0]   p_r, p_nxt;
  logic [fmc_pkg::DIV_W-1:0]    d1_r;
  fmc_pkg::fmc_side_t           side1_r;

  // stage 2: divider setup
  fmc_pkg::fmc_dq_t             dq_r, dq_nxt;

  logic signed [17:0] rel_sum;
  logic signed [17:0] max_ext, min_ext;
  logic signed [24:0] acc_ext, abs_ext;
  logic [fmc_pkg::HI_W-1:0] hi;

  assign en[2]    = !v_r[2] || dn_ready;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[2];
  assign dn_data  = dq_r;

  always_comb begin
    p1_nxt = 28'(up_data.charge_density) * 28'(cfg.cylinder_volume);
    d0_nxt = fmc_pkg::DIV_W'(up_data.afr_setpoint) * fmc_pkg::DIV_W'(fmc_pkg::AFR_SCALE);

    rel_sum = '0;
    if (up_data.ase_on) begin
      rel_sum = rel_sum + {{2{up_data.ase_percent[15]}}, up_data.ase_percent};
    end
    if (up_data.wue_on) begin
      rel_sum = rel_sum + {{2{up_data.wue_percent[15]}}, up_data.wue_percent};
    end
    if (up_data.baro_on) begin
      rel_sum = rel_sum + {{2{up_data.baro_percent[15]}}, up_data.baro_percent};
    end
    max_ext = {{2{cfg.max_rel_comp[15]}}, cfg.max_rel_comp};
    min_ext = {{2{cfg.min_rel_comp[15]}}, cfg.min_rel_comp};

    side0_nxt.derr = (up_data.afr_setpoint == '0);
    side0_nxt.rel  = rel_sum[15:0];
    side0_nxt.relc = 1'b0;
    // upper limit wins when the limits cross; a zero sum is never clipped
    if (rel_sum != '0) begin
      if (rel_sum > max_ext) begin
        side0_nxt.rel  = cfg.max_rel_comp;
        side0_nxt.relc = 1'b1;
      end else if (rel_sum < min_ext) begin
        side0_nxt.rel  = cfg.min_rel_comp;
        side0_nxt.relc = 1'b1;
      end
    end

    acc_ext = {up_data.accel_mass[23], up_data.accel_mass};
    abs_ext = {9'b0, cfg.max_abs_comp};
    side0_nxt.accel = '0;
    side0_nxt.absc  = 1'b0;
    if (up_data.accel_on) begin
      if (acc_ext > abs_ext) begin
        side0_nxt.accel = {8'b0, cfg.max_abs_comp};
        side0_nxt.absc  = 1'b1;
      end else begin
        side0_nxt.accel = up_data.accel_mass;
      end
    end
  end

  assign p_nxt = fmc_pkg::PROD_W'(p1_r) * fmc_pkg::PROD_W'(ve_r);

  always_comb begin
    hi          = p_r[fmc_pkg::PROD_W-1:fmc_pkg::QUO_W];
    dq_nxt.rem  = fmc_pkg::DIV_W'(hi);
    dq_nxt.qp   = p_r[fmc_pkg::QUO_W-1:0];
    dq_nxt.d    = d1_r;
    dq_nxt.ovf  = (fmc_pkg::DIV_W'(hi) >= d1_r);
    dq_nxt.side = side1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r    <= p1_nxt;
      ve_r    <= up_data.ve_percent;
      d0_r    <= d0_nxt;
      side0_r <= side0_nxt;
    end
    if (en[1]) begin
      p_r     <= p_nxt;
      d1_r    <= d0_r;
      side1_r <= side0_r;
    end
    if (en[2]) begin
      dq_r    <= dq_nxt;
    end
  end

endmodule

@@ hw/rtl/fmc_div.sv @@
module fmc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  fmc_pkg::fmc_dq_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output fmc_pkg::fmc_dq_t dn_data
);

  localparam int LAST = fmc_pkg::QUO_W - 1;

  logic [fmc_pkg::QUO_W-1:0] v_r;
  logic [fmc_pkg::QUO_W:0]   rdy;
  fmc_pkg::fmc_dq_t          st_r [fmc_pkg::QUO_W];

  assign rdy[fmc_pkg::QUO_W] = dn_ready;
  assign up_ready = rdy[0];
  assign dn_valid = v_r[LAST];
  assign dn_data  = st_r[LAST];

  // one restoring step per stage, quotient msb first
  for (genvar k = 0; k < fmc_pkg::QUO_W; k++) begin : g_step
    fmc_pkg::fmc_dq_t cur, st_nxt;
    logic             vin;
    logic [fmc_pkg::DIV_W:0] trial, dext;
    logic             ge;

    if (k == 0) begin : g_first
      assign cur = up_data;
      assign vin = up_valid;
    end else begin : g_next
      assign cur = st_r[k-1];
      assign vin = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      trial  = {cur.rem, cur.qp[fmc_pkg::QUO_W-1]};
      dext   = {1'b0, cur.d};
      ge     = (trial >= dext);
      st_nxt = cur;
      st_nxt.rem = ge ? fmc_pkg::DIV_W'(trial - dext) : trial[fmc_pkg::DIV_W-1:0];
      st_nxt.qp  = {cur.qp[fmc_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !st_r[LAST].side.derr && !st_r[LAST].ovf
      |-> st_r[LAST].rem < st_r[LAST].d)
    else $error("divider remainder not below divisor");

endmodule

@@ hw/rtl/fmc_trim.sv @@
module fmc_trim (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  fmc_pkg::fmc_dq_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fmc_pkg::fmc_out_t dn_data
);

  typedef struct packed {
    logic [fmc_pkg::BASE_W-1:0] base;
    logic                       derr;
    logic                       relc;
    logic                       absc;
    logic                       bsat;
  } fmc_flag_t;

  logic [3:0] v_r;
  logic [3:0] en;

  fmc_flag_t          fl0_r, fl0_nxt, fl1_r, fl2_r;
  logic signed [43:0] prod_r, prod_nxt;
  logic signed [35:0] acc_r, acc_nxt;
  logic signed [16:0] fac;

  logic signed [44:0] num;
  logic               pos;
  logic [35:0]        n6;
  logic [31:0]        nq_r;
  logic               zero1_r, tsat1_r, zero2_r, tsat2_r;

  logic [63:0]        m_r, m_nxt;

  fmc_pkg::fmc_out_t  out_r, out_nxt;

  assign en[3]    = !v_r[3] || dn_ready;
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[3];
  assign dn_data  = out_r;

  // stage 0: pick base, scale by (1600 + rel), accel * 1600
  always_comb begin
    fl0_nxt.derr = up_data.side.derr;
    fl0_nxt.relc = up_data.side.relc;
    fl0_nxt.absc = up_data.side.absc;
    fl0_nxt.bsat = !up_data.side.derr && up_data.ovf;
    if (up_data.side.derr) begin
      fl0_nxt.base = '0;
    end else if (up_data.ovf) begin
      fl0_nxt.base = fmc_pkg::BASE_MAX;
    end else begin
      fl0_nxt.base = up_data.qp;
    end
    fac      = 17'(fmc_pkg::PCT_SCALE) + {up_data.side.rel[15], up_data.side.rel};
    prod_nxt = $signed({18'b0, fl0_nxt.base}) * $signed({{27{fac[16]}}, fac});
    acc_nxt  = $signed({{12{up_data.side.accel[23]}}, up_data.side.accel})
             * 36'(fmc_pkg::PCT_SCALE);
  end

  // stage 1: sum, sign and range check, drop the factor of 64
  always_comb begin
    num = {prod_r[43], prod_r} + {{9{acc_r[35]}}, acc_r};
    pos = !num[44] && (num != '0);
    n6  = num[fmc_pkg::PCT_SHIFT+35:fmc_pkg::PCT_SHIFT];
  end

  // stage 2: divide by 25 through the reciprocal
  assign m_nxt = 64'(nq_r) * 64'(fmc_pkg::RECIP_25);

  // stage 3: result register
  always_comb begin
    out_nxt.base_mass    = fl2_r.base;
    out_nxt.divide_error = fl2_r.derr;
    out_nxt.rel_clipped  = fl2_r.relc;
    out_nxt.abs_clipped  = fl2_r.absc;
    out_nxt.saturated    = fl2_r.bsat || tsat2_r;
    if (zero2_r) begin
      out_nxt.target_mass = '0;
    end else if (tsat2_r) begin
      out_nxt.target_mass = fmc_pkg::TARGET_MAX;
    end else begin
      out_nxt.target_mass = m_r[fmc_pkg::RECIP_SHIFT+fmc_pkg::TARGET_W-1:fmc_pkg::RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fl0_r  <= fl0_nxt;
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
    if (en[1]) begin
      fl1_r   <= fl0_r;
      nq_r    <= n6[31:0];
      zero1_r <= !pos;
      tsat1_r <= pos && (n6 >= fmc_pkg::TGT_LIMIT);
    end
    if (en[2]) begin
      fl2_r   <= fl1_r;
      m_r     <= m_nxt;
      zero2_r <= zero1_r;
      tsat2_r <= tsat1_r;
    end
    if (en[3]) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ hw/rtl/fuel_mass_with_corrections.sv @@
// Speed-density fuel mass per cylinder with relative and absolute corrections.
//
// Input channel: in_valid / in_stall / in_data carries one request. A request
// transfers on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall / out_data carries one result per
// request, in request order; it transfers when out_valid is high and
// out_stall low. out_data holds steady while stalled.
// Configuration: cfg_we, cfg_idx, cfg_wdata write one register per cycle;
// write only while no request is in flight.
//
// A request passes through the multiplies and divider setup, then the
// restoring divider (one quotient bit per stage), then scaling, the divide
// by 1600 and the result register. Throughput is one request per cycle
// while the receiver does not stall. Each stage advances when the next one
// is empty or moving, so bubbles close up under a stall; in_stall rises
// only once every stage holds a request and the receiver stalls.
// Synchronous reset empties the pipeline and loads the register defaults.
module fuel_mass_with_corrections (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fmc_pkg::fmc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fmc_pkg::fmc_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata
);

  fmc_pkg::fmc_cfg_t cfg_r;

  logic             air_ready;
  logic             a2d_valid, a2d_ready;
  fmc_pkg::fmc_dq_t a2d_data;
  logic             d2t_valid, d2t_ready;
  fmc_pkg::fmc_dq_t d2t_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cylinder_volume <= fmc_pkg::CYL_VOL_RST;
      cfg_r.max_rel_comp    <= fmc_pkg::MAX_REL_RST;
      cfg_r.min_rel_comp    <= fmc_pkg::MIN_REL_RST;
      cfg_r.max_abs_comp    <= fmc_pkg::MAX_ABS_RST;
    end else if (cfg_we) begin
      unique case (fmc_pkg::fmc_reg_t'(cfg_idx))
        fmc_pkg::REG_CYL_VOL: cfg_r.cylinder_volume <= cfg_wdata[11:0];
        fmc_pkg::REG_MAX_REL: cfg_r.max_rel_comp    <= cfg_wdata;
        fmc_pkg::REG_MIN_REL: cfg_r.min_rel_comp    <= cfg_wdata;
        fmc_pkg::REG_MAX_ABS: cfg_r.max_abs_comp    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = !air_ready;

  fmc_air u_air (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (air_ready),
    .up_data  (in_data),
    .dn_valid (a2d_valid),
    .dn_ready (a2d_ready),
    .dn_data  (a2d_data)
  );

  fmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a2d_valid),
    .up_ready (a2d_ready),
    .up_data  (a2d_data),
    .dn_valid (d2t_valid),
    .dn_ready (d2t_ready),
    .dn_data  (d2t_data)
  );

  fmc_trim u_trim (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d2t_valid),
    .up_ready (d2t_ready),
    .up_data  (d2t_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is moving");

  a_derr_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |-> out_data.base_mass == '0)
    else $error("divide error with nonzero base mass");

endmodule
